// File: rtl/dmtt_pkg.sv
// Shared types and constants of the direct-mapped transposition table.
package dmtt_pkg;

    // Table geometry: each side owns 2^INDEX_BITS entries.
    localparam int INDEX_BITS = 16;
    localparam int ADDR_BITS  = INDEX_BITS + 1;
    localparam int KEY_BITS   = 32;
    localparam int SCORE_BITS = 16;
    localparam int EP_BITS    = 8;

    // Score reported on a miss.
    localparam logic signed [SCORE_BITS-1:0] MISS_SCORE = 16'sh7FFF;

    // Command codes.
    typedef enum logic {
        OP_STORE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    // One input item.
    typedef struct packed {
        t_op                            opcode;
        logic                           side;
        logic [KEY_BITS-1:0]            position_key;
        logic                           king_castle_right;
        logic                           queen_castle_right;
        logic [EP_BITS-1:0]             en_passant_flags;
        logic signed [SCORE_BITS-1:0]   score_in;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic                           hit;
        logic signed [SCORE_BITS-1:0]   score_out;
    } t_result;

    // One stored table entry.
    typedef struct packed {
        logic [KEY_BITS-1:0]            key;
        logic                           king_castle;
        logic                           queen_castle;
        logic [EP_BITS-1:0]             ep_flags;
        logic signed [SCORE_BITS-1:0]   score;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    // Lookup request carried from the read stage to the compare stage.
    typedef struct packed {
        logic                           valid;
        logic [KEY_BITS-1:0]            key;
        logic                           king_castle;
        logic                           queen_castle;
        logic [EP_BITS-1:0]             ep_flags;
    } t_probe;

endpackage

// File: rtl/direct_mapped_transposition_table.sv
// Top level of the two-sided direct-mapped transposition table.
// A lookup passes the probe and RAM read registers, then the result register, before o_strobe.
// Throughput: one item per cycle while o_busy is low (single-port entry RAM); stores give no result.
// Reset: i_rst_n clears control state and starts a sweep that zeroes all 2^(INDEX_BITS+1) entries,
// one per cycle; o_busy is high for the whole sweep.
// The receiver cannot stall: every result is on the ports for exactly one cycle.
module direct_mapped_transposition_table
    import dmtt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_strobe,
    output t_result o_result
);

    logic                 r_clearing;
    logic [ADDR_BITS-1:0] r_clr_addr;
    t_probe               r_probe;
    logic                 w_accept;
    logic                 w_we;
    logic [ADDR_BITS-1:0] w_addr;
    t_entry               w_wentry;
    logic [ENTRY_BITS-1:0] w_rdata;
    t_entry               w_rentry;

    assign w_accept = i_start && !r_clearing;
    assign o_busy   = r_clearing;

    // Clearing sweep after reset, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // RAM port: the sweep, a store, or a lookup read.
    always_comb begin
        w_wentry.key          = i_cmd.position_key;
        w_wentry.king_castle  = i_cmd.king_castle_right;
        w_wentry.queen_castle = i_cmd.queen_castle_right;
        w_wentry.ep_flags     = i_cmd.en_passant_flags;
        w_wentry.score        = i_cmd.score_in;
        if (r_clearing) begin
            w_we     = 1'b1;
            w_addr   = r_clr_addr;
            w_wentry = '0;
        end else begin
            w_we   = i_start && (i_cmd.opcode == OP_STORE);
            w_addr = {i_cmd.side, i_cmd.position_key[INDEX_BITS-1:0]};
        end
    end

    // Probe fields travel alongside the RAM read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= w_accept && (i_cmd.opcode == OP_LOOKUP);
        end
        r_probe.key          <= i_cmd.position_key;
        r_probe.king_castle  <= i_cmd.king_castle_right;
        r_probe.queen_castle <= i_cmd.queen_castle_right;
        r_probe.ep_flags     <= i_cmd.en_passant_flags;
    end

    dmtt_ram #(
        .ADDR_W (ADDR_BITS),
        .DATA_W (ENTRY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wentry),
        .o_rdata (w_rdata)
    );

    assign w_rentry = t_entry'(w_rdata);

    dmtt_match u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_probe  (r_probe),
        .i_entry  (w_rentry),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // No result can come out while the table is being cleared.
    a_no_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_strobe)
        else $error("result during clearing sweep");

    // Each result traces back to an accepted lookup, through the probe register and the result register.
    a_strobe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start && !o_busy && (i_cmd.opcode == OP_LOOKUP), 2))
        else $error("result without a matching lookup");

    // The sweep ends only after the last entry has been written.
    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> (&$past(r_clr_addr)))
        else $error("clearing sweep ended early");

endmodule

// File: rtl/dmtt_ram.sv
// Single-port synchronous RAM with registered read data.
module dmtt_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // Write on request, otherwise read the addressed entry.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/dmtt_match.sv
// Compare stage: checks a read entry against the probe and registers the result.
module dmtt_match
    import dmtt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_probe  i_probe,
    input  t_entry  i_entry,
    output logic    o_strobe,
    output t_result o_result
);

    logic    n_hit;
    t_result n_result;
    logic    r_strobe;
    t_result r_result;

    // A hit needs the key and every flag to agree.
    always_comb begin
        n_hit = (i_entry.key == i_probe.key)
             && (i_entry.king_castle == i_probe.king_castle)
             && (i_entry.queen_castle == i_probe.queen_castle)
             && (i_entry.ep_flags == i_probe.ep_flags);
        n_result.hit       = n_hit;
        n_result.score_out = n_hit ? i_entry.score : MISS_SCORE;
    end

    // Strobe is control state; the result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_probe.valid;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A reported miss always carries the miss score.
    a_miss_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.hit) |-> (o_result.score_out == MISS_SCORE))
        else $error("miss reported without the miss score");

    // A strobe appears only in the cycle after a valid probe.
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_probe.valid))
        else $error("strobe without a probe");

endmodule

// File: bench/tb_direct_mapped_transposition_table.sv
// Self-checking testbench for the two-sided direct-mapped transposition table.
`timescale 1ns / 1ps

module tb_direct_mapped_transposition_table;
    import dmtt_pkg::*;

    // Index widths for picking one bit of the key or of the en-passant flags.
    localparam int KEY_SEL_BITS = $clog2(KEY_BITS);
    localparam int EP_SEL_BITS  = $clog2(EP_BITS);

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    o_busy;
    logic    o_strobe;
    t_result o_result;

    // Image of both tables, indexed by {side, slot}; absent entries read as zero.
    t_entry  table_image [bit [ADDR_BITS-1:0]];
    // Lookup results still owed by the block, oldest first.
    t_result pending_scores [$];
    // Recently stored entries, reused to build lookups that should hit.
    t_cmd    stored_pool [$];
    int      mismatch_count = 0;
    bit      no_idle = 1'b0;

    direct_mapped_transposition_table uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_cmd build_cmd(input t_op op, input logic sd,
                                       input logic [KEY_BITS-1:0] key,
                                       input logic kc, input logic qc,
                                       input logic [EP_BITS-1:0] ep,
                                       input logic signed [SCORE_BITS-1:0] score);
        t_cmd c;
        c.opcode             = op;
        c.side               = sd;
        c.position_key       = key;
        c.king_castle_right  = kc;
        c.queen_castle_right = qc;
        c.en_passant_flags   = ep;
        c.score_in           = score;
        return c;
    endfunction

    // Apply one command to the table image and work out the lookup result, if any.
    function automatic void mirror_command(input t_cmd c, output bit has_res,
                                           output t_result r);
        bit [ADDR_BITS-1:0] slot;
        t_entry e;
        slot = {c.side, c.position_key[INDEX_BITS-1:0]};
        e = table_image.exists(slot) ? table_image[slot] : '0;
        r = '0;
        if (c.opcode == OP_STORE) begin
            e.key          = c.position_key;
            e.king_castle  = c.king_castle_right;
            e.queen_castle = c.queen_castle_right;
            e.ep_flags     = c.en_passant_flags;
            e.score        = c.score_in;
            table_image[slot] = e;
            has_res = 1'b0;
        end else begin
            has_res = 1'b1;
            if (e.key == c.position_key && e.king_castle == c.king_castle_right &&
                e.queen_castle == c.queen_castle_right &&
                e.ep_flags == c.en_passant_flags) begin
                r.hit       = 1'b1;
                r.score_out = e.score;
            end else begin
                r.hit       = 1'b0;
                r.score_out = MISS_SCORE;
            end
        end
    endfunction

    // Present one item, wait until it is taken, then idle for a random while unless no_idle is set.
    task automatic issue_item(input t_cmd c);
        bit          has_res;
        t_result     r;
        int unsigned gap;
        i_start <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (o_busy);
        mirror_command(c, has_res, r);
        if (has_res) pending_scores.push_back(r);
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Every strobed result is compared with the oldest pending expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_scores.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result hit=%0b score=%0d",
                             $realtime, o_result.hit, o_result.score_out);
            end else begin
                want = pending_scores.pop_front();
                if (o_result.hit !== want.hit || o_result.score_out !== want.score_out) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected hit=%0b score=%0d, got hit=%0b score=%0d",
                                 $realtime, want.hit, want.score_out,
                                 o_result.hit, o_result.score_out);
                end
            end
        end
    end

    // Entries cleared by the reset sweep hit only for key 0 with all flags clear.
    task automatic test_cleared_table();
        issue_item(build_cmd(OP_LOOKUP, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00, 16'sh0));
        issue_item(build_cmd(OP_LOOKUP, 1'b1, 32'h0, 1'b0, 1'b0, 8'h00, 16'sh7FFF));
        issue_item(build_cmd(OP_LOOKUP, 1'b0, 32'h0001_0000, 1'b0, 1'b0, 8'h00, 16'sh0));
        issue_item(build_cmd(OP_LOOKUP, 1'b0, 32'h0, 1'b1, 1'b0, 8'h00, 16'sh0));
        issue_item(build_cmd(OP_LOOKUP, 1'b1, 32'h0, 1'b0, 1'b0, 8'h01, -16'sh1));
    endtask

    // Extreme keys, flags and scores, including a hit on a stored 32767.
    task automatic test_field_extremes();
        issue_item(build_cmd(OP_STORE, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 16'sh7FFF));
        issue_item(build_cmd(OP_LOOKUP, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 16'sh0));
        issue_item(build_cmd(OP_LOOKUP, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 16'sh0));
        issue_item(build_cmd(OP_STORE, 1'b1, 32'h8000_FFFF, 1'b0, 1'b0, 8'h00, -16'sh8000));
        issue_item(build_cmd(OP_LOOKUP, 1'b1, 32'h8000_FFFF, 1'b0, 1'b0, 8'h00, 16'sh7FFF));
        issue_item(build_cmd(OP_STORE, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 16'sh0));
        issue_item(build_cmd(OP_LOOKUP, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 16'sh0));
    endtask

    // A single differing flag must turn a hit into a miss.
    task automatic test_flag_mismatch();
        issue_item(build_cmd(OP_LOOKUP, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'hFF, 16'sh0));
        issue_item(build_cmd(OP_LOOKUP, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'hFF, 16'sh0));
        issue_item(build_cmd(OP_LOOKUP, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'h7F, 16'sh0));
    endtask

    // Keys sharing a slot overwrite each other; the upper key bits must be compared.
    task automatic test_slot_alias();
        issue_item(build_cmd(OP_STORE, 1'b0, 32'h1234_0005, 1'b0, 1'b1, 8'h80, -16'sh1));
        issue_item(build_cmd(OP_LOOKUP, 1'b0, 32'h1234_0005, 1'b0, 1'b1, 8'h80, 16'sh0));
        issue_item(build_cmd(OP_STORE, 1'b0, 32'h5678_0005, 1'b1, 1'b0, 8'h01, 16'sh1));
        issue_item(build_cmd(OP_LOOKUP, 1'b0, 32'h1234_0005, 1'b0, 1'b1, 8'h80, 16'sh0));
        issue_item(build_cmd(OP_LOOKUP, 1'b0, 32'h5678_0005, 1'b1, 1'b0, 8'h01, 16'sh0));
    endtask

    // Mostly store/lookup traffic over recent entries, with corrupted probes and noise.
    task automatic test_random_traffic(input int count);
        t_cmd        c;
        int unsigned pick;
        int unsigned k;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            c = build_cmd(OP_LOOKUP, 1'($urandom_range(0, 1)), $urandom(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          EP_BITS'($urandom_range(0, 255)),
                          SCORE_BITS'($urandom_range(0, 65535)));
            if (pick < 40 || stored_pool.size() == 0) begin
                // Store a fresh entry, or overwrite the slot of a known one.
                c.opcode = OP_STORE;
                if (stored_pool.size() != 0 && $urandom_range(0, 3) == 0) begin
                    k = $urandom_range(0, stored_pool.size() - 1);
                    c.side = stored_pool[k].side;
                    c.position_key[INDEX_BITS-1:0] =
                        stored_pool[k].position_key[INDEX_BITS-1:0];
                end
                stored_pool.push_back(c);
                if (stored_pool.size() > 64) void'(stored_pool.pop_front());
            end else if (pick < 90) begin
                // Probe a known entry, sometimes with one field disturbed.
                k = $urandom_range(0, stored_pool.size() - 1);
                c = stored_pool[k];
                c.opcode = OP_LOOKUP;
                c.score_in = SCORE_BITS'($urandom_range(0, 65535));
                if ($urandom_range(0, 9) < 3) begin
                    case ($urandom_range(0, 4))
                        0: c.position_key[KEY_SEL_BITS'($urandom_range(0, KEY_BITS - 1))]
                               ^= 1'b1;
                        1: c.king_castle_right = ~c.king_castle_right;
                        2: c.queen_castle_right = ~c.queen_castle_right;
                        3: c.en_passant_flags[EP_SEL_BITS'($urandom_range(0, EP_BITS - 1))]
                               ^= 1'b1;
                        default: c.side = ~c.side;
                    endcase
                end
            end
            issue_item(c);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_table();
        test_field_extremes();
        test_flag_mismatch();
        test_slot_alias();
        test_random_traffic(1430);

        i_start <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
